/* design/ipid_pkg.sv */
package ipid_pkg;

  localparam int AXES      = 3;
  localparam int TARGET_W  = 16;
  localparam int GAIN_W    = 16;
  // derived gains need two extra bits: kp + 2*kd and kp + ki + kd
  localparam int K_W       = GAIN_W + 2;
  localparam int ACC_W     = 40;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd512;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd3;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X = 3'd0,
    REG_TARGET_Y = 3'd1,
    REG_TARGET_Z = 3'd2,
    REG_GAIN_P   = 3'd3,
    REG_GAIN_I   = 3'd4,
    REG_GAIN_D   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ACT_RUN   = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

  // velocity-form coefficients: k0 = p+i+d, k1 = -p-2d, k2 = d
  typedef struct packed {
    logic signed [K_W-1:0] k0;
    logic signed [K_W-1:0] k1;
    logic signed [K_W-1:0] k2;
  } gains_t;

endpackage

/* design/incremental_pid_three_axis_core.sv */
// Three-axis velocity-form PID core.
// Input stream (in_*): one word per control update. in_tdata carries
// measured_x, measured_y, measured_z (SAMPLE_WIDTH bits each, x lowest);
// in_tuser[0] is the action: run one update, or clear history and drives.
// Output stream (out_*): exactly one word per input word, drive_x/y/z
// (32 bits each, x lowest) in out_tdata and per-axis clip flags in out_tuser.
// Config port (cfg_*): index 0..2 targets x/y/z, 3..5 gains p/i/d (Q8.8).
// Always ready; write only while no update is in flight. Unknown indexes
// are dropped.
// Data path: an accepted word lands in the input register, is computed
// combinationally and captured into the output register.
// Throughput: one word per cycle while out_tready is high; each axis has one multiply-add path and
// the per-axis state (error history, 40-bit accumulator) updates in the
// same cycle the result is captured.
// Stall: when out_tready is low the output register holds and the input
// register can still take one word; in_tready drops once both are full.
// Reset (rst_n low, synchronous): both stages empty, history and
// accumulators zero, targets zero, gains p=2.0, i=3/256, d=0.
module incremental_pid_three_axis_core #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // measured_x, measured_y, measured_z (low to high), zero padded
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,
  // action
  input  logic [0:0]                            in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // drive_x, drive_y, drive_z (low to high)
  output logic [3*ipid_pkg::OUT_W-1:0]          out_tdata,
  // saturated (bit 0 x, bit 1 y, bit 2 z)
  output logic [ipid_pkg::AXES-1:0]             out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ipid_pkg::CFG_DAT_W-1:0]        cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int OW = ipid_pkg::OUT_W;

  logic signed [ipid_pkg::TARGET_W-1:0] target_x, target_y, target_z;
  ipid_pkg::gains_t                     gains;

  // input register
  logic                 s1_valid_r;
  logic                 s1_action_r;
  logic signed [SW-1:0] s1_mx_r, s1_my_r, s1_mz_r;

  // output register
  logic                 out_valid_r;
  logic [3*OW-1:0]      out_data_r;
  logic [2:0]           out_sat_r;

  logic                 out_free;
  logic                 s1_go;
  logic                 s1_clear;
  logic signed [OW-1:0] drv_x, drv_y, drv_z;
  logic                 sat_x, sat_y, sat_z;

  assign cfg_ready = 1'b1;

  ipid_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .target_x (target_x),
    .target_y (target_y),
    .target_z (target_z),
    .gains    (gains)
  );

  // output side frees up this edge if empty or being taken
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign s1_clear  = (ipid_pkg::action_t'(s1_action_r) == ipid_pkg::ACT_CLEAR);

  ipid_axis #(.SAMPLE_WIDTH(SW), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .clear  (s1_clear),
    .target (target_x),
    .meas   (s1_mx_r),
    .gains  (gains),
    .drive  (drv_x),
    .sat    (sat_x)
  );

  ipid_axis #(.SAMPLE_WIDTH(SW), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .clear  (s1_clear),
    .target (target_y),
    .meas   (s1_my_r),
    .gains  (gains),
    .drive  (drv_y),
    .sat    (sat_y)
  );

  ipid_axis #(.SAMPLE_WIDTH(SW), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_axis_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_go),
    .clear  (s1_clear),
    .target (target_z),
    .meas   (s1_mz_r),
    .gains  (gains),
    .drive  (drv_z),
    .sat    (sat_z)
  );

  // handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_action_r <= in_tuser[0];
      s1_mx_r     <= in_tdata[SW-1:0];
      s1_my_r     <= in_tdata[2*SW-1:SW];
      s1_mz_r     <= in_tdata[3*SW-1:2*SW];
    end
    if (s1_go) begin
      out_data_r <= {drv_z, drv_y, drv_x};
      out_sat_r  <= {sat_z, sat_y, sat_x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

/* design/ipid_cfg_regs.sv */
module ipid_cfg_regs (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    wr_en,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]          wr_index,
  input  logic [ipid_pkg::CFG_DAT_W-1:0]          wr_data,
  output logic signed [ipid_pkg::TARGET_W-1:0]    target_x,
  output logic signed [ipid_pkg::TARGET_W-1:0]    target_y,
  output logic signed [ipid_pkg::TARGET_W-1:0]    target_z,
  output ipid_pkg::gains_t                        gains
);

  logic signed [ipid_pkg::TARGET_W-1:0] tx_r, ty_r, tz_r;
  logic signed [ipid_pkg::TARGET_W-1:0] tx_nxt, ty_nxt, tz_nxt;
  logic signed [ipid_pkg::GAIN_W-1:0]   gp_r, gi_r, gd_r;
  logic signed [ipid_pkg::GAIN_W-1:0]   gp_nxt, gi_nxt, gd_nxt;
  ipid_pkg::gains_t                     k_r, k_nxt;

  always_comb begin
    tx_nxt = tx_r;
    ty_nxt = ty_r;
    tz_nxt = tz_r;
    gp_nxt = gp_r;
    gi_nxt = gi_r;
    gd_nxt = gd_r;
    if (wr_en) begin
      unique case (ipid_pkg::cfg_reg_t'(wr_index))
        ipid_pkg::REG_TARGET_X: tx_nxt = wr_data;
        ipid_pkg::REG_TARGET_Y: ty_nxt = wr_data;
        ipid_pkg::REG_TARGET_Z: tz_nxt = wr_data;
        ipid_pkg::REG_GAIN_P:   gp_nxt = wr_data;
        ipid_pkg::REG_GAIN_I:   gi_nxt = wr_data;
        ipid_pkg::REG_GAIN_D:   gd_nxt = wr_data;
        default: ;
      endcase
    end
  end

  // coefficients follow the gain registers in the same edge
  always_comb begin
    k_nxt.k0 = ipid_pkg::K_W'(gp_nxt) + ipid_pkg::K_W'(gi_nxt) + ipid_pkg::K_W'(gd_nxt);
    k_nxt.k1 = -ipid_pkg::K_W'(gp_nxt) - (ipid_pkg::K_W'(gd_nxt) <<< 1);
    k_nxt.k2 = ipid_pkg::K_W'(gd_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r    <= '0;
      ty_r    <= '0;
      tz_r    <= '0;
      gp_r    <= ipid_pkg::GAIN_P_RST;
      gi_r    <= ipid_pkg::GAIN_I_RST;
      gd_r    <= ipid_pkg::GAIN_D_RST;
      k_r.k0  <= ipid_pkg::K_W'(ipid_pkg::GAIN_P_RST) + ipid_pkg::K_W'(ipid_pkg::GAIN_I_RST)
                 + ipid_pkg::K_W'(ipid_pkg::GAIN_D_RST);
      k_r.k1  <= -ipid_pkg::K_W'(ipid_pkg::GAIN_P_RST)
                 - (ipid_pkg::K_W'(ipid_pkg::GAIN_D_RST) <<< 1);
      k_r.k2  <= ipid_pkg::K_W'(ipid_pkg::GAIN_D_RST);
    end else begin
      tx_r <= tx_nxt;
      ty_r <= ty_nxt;
      tz_r <= tz_nxt;
      gp_r <= gp_nxt;
      gi_r <= gi_nxt;
      gd_r <= gd_nxt;
      k_r  <= k_nxt;
    end
  end

  assign target_x = tx_r;
  assign target_y = ty_r;
  assign target_z = tz_r;
  assign gains    = k_r;

endmodule

/* design/ipid_axis.sv */
module ipid_axis #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  logic                                  clear,
  input  logic signed [ipid_pkg::TARGET_W-1:0]  target,
  input  logic signed [SAMPLE_WIDTH-1:0]        meas,
  input  ipid_pkg::gains_t                      gains,
  output logic signed [ipid_pkg::OUT_W-1:0]     drive,
  output logic                                  sat
);

  localparam int EW    = ((SAMPLE_WIDTH > ipid_pkg::TARGET_W) ? SAMPLE_WIDTH
                          : ipid_pkg::TARGET_W) + 1;
  localparam int PW    = ipid_pkg::K_W + EW;
  localparam int SUM_W = ((PW > ipid_pkg::ACC_W) ? PW : ipid_pkg::ACC_W) + 2;
  localparam int ACC_W = ipid_pkg::ACC_W;
  localparam int OUT_W = ipid_pkg::OUT_W;
  localparam int WH_W  = ACC_W - GAIN_FRAC_BITS;

  logic signed [EW-1:0]    err1_r, err2_r, err_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0]    p0, p1, p2;
  logic signed [SUM_W-1:0] sum;
  logic                    acc_ovf, out_ovf;
  logic signed [ACC_W-1:0] shifted;
  logic signed [WH_W-1:0]  whole;
  logic signed [OUT_W-1:0] drive_c;

  assign err_nxt = EW'(target) - EW'(meas);

  assign p0 = PW'(gains.k0) * PW'(err_nxt);
  assign p1 = PW'(gains.k1) * PW'(err1_r);
  assign p2 = PW'(gains.k2) * PW'(err2_r);

  assign sum = SUM_W'(acc_r) + SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);

  // clip to the accumulator range: upper bits must all match its sign bit
  assign acc_ovf = (sum[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){sum[ACC_W-1]}});

  always_comb begin
    if (!acc_ovf) begin
      acc_nxt = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      acc_nxt = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_nxt = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // integer part, rounding toward minus infinity
  assign shifted = acc_nxt >>> GAIN_FRAC_BITS;
  assign whole   = shifted[WH_W-1:0];

  generate
    if (WH_W > OUT_W) begin : g_clip
      assign out_ovf = (whole[WH_W-1:OUT_W-1] != {(WH_W-OUT_W+1){whole[OUT_W-1]}});
      always_comb begin
        if (!out_ovf) begin
          drive_c = whole[OUT_W-1:0];
        end else if (whole[WH_W-1]) begin
          drive_c = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          drive_c = {1'b0, {(OUT_W-1){1'b1}}};
        end
      end
    end else begin : g_fit
      assign out_ovf = 1'b0;
      assign drive_c = OUT_W'(whole);
    end
  endgenerate

  assign drive = clear ? '0 : drive_c;
  assign sat   = !clear && (acc_ovf || out_ovf);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err1_r <= '0;
      err2_r <= '0;
      acc_r  <= '0;
    end else if (step) begin
      if (clear) begin
        err1_r <= '0;
        err2_r <= '0;
        acc_r  <= '0;
      end else begin
        err2_r <= err1_r;
        err1_r <= err_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

endmodule

/* sim/tb_incremental_pid_three_axis_core.sv */
`timescale 1ns / 1ps

localparam int TB_SAMPLE_W  = 16;
localparam int TB_FRAC_BITS = 8;
localparam int ERR_W        = ipid_pkg::TARGET_W + 1;

localparam longint ACC_HI = (longint'(1) <<< (ipid_pkg::ACC_W - 1)) - 1;
localparam longint ACC_LO = -ACC_HI - 1;
localparam longint OUT_HI = (longint'(1) <<< (ipid_pkg::OUT_W - 1)) - 1;
localparam longint OUT_LO = -OUT_HI - 1;

// one result word: drive_x in drive[0], clip flag of axis a in clipped[a]
typedef struct packed {
  logic [ipid_pkg::AXES-1:0]                     clipped;
  logic [ipid_pkg::AXES-1:0][ipid_pkg::OUT_W-1:0] drive;
} drive_word_t;

class pid_scoreboard;
  logic signed [ipid_pkg::TARGET_W-1:0] setpoint[ipid_pkg::AXES];
  logic signed [ipid_pkg::GAIN_W-1:0]   kp, ki, kd;
  logic signed [ERR_W-1:0]              err_last[ipid_pkg::AXES];
  logic signed [ERR_W-1:0]              err_older[ipid_pkg::AXES];
  logic signed [ipid_pkg::ACC_W-1:0]    accum[ipid_pkg::AXES];
  drive_word_t                          drive_q[$];
  int mismatches, words_checked, clear_words, clip_words;

  function new();
    for (int a = 0; a < ipid_pkg::AXES; a++) begin
      setpoint[a]  = '0;
      err_last[a]  = '0;
      err_older[a] = '0;
      accum[a]     = '0;
    end
    kp = ipid_pkg::GAIN_P_RST;
    ki = ipid_pkg::GAIN_I_RST;
    kd = ipid_pkg::GAIN_D_RST;
    mismatches    = 0;
    words_checked = 0;
    clear_words   = 0;
    clip_words    = 0;
  endfunction

  function int pending();
    return drive_q.size();
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // unmapped indexes fall through and change nothing
  function void write_reg(logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                          logic [ipid_pkg::CFG_DAT_W-1:0] val);
    case (idx)
      ipid_pkg::REG_TARGET_X: setpoint[0] = val;
      ipid_pkg::REG_TARGET_Y: setpoint[1] = val;
      ipid_pkg::REG_TARGET_Z: setpoint[2] = val;
      ipid_pkg::REG_GAIN_P:   kp = val;
      ipid_pkg::REG_GAIN_I:   ki = val;
      ipid_pkg::REG_GAIN_D:   kd = val;
      default: ;
    endcase
  endfunction

  // accepted input word -> expected drive word
  function void note_input(ipid_pkg::action_t act, logic [3*TB_SAMPLE_W-1:0] samples);
    longint k0, k1, k2, e, sum, whole;
    logic signed [TB_SAMPLE_W-1:0] meas;
    drive_word_t w;
    w = '0;
    if (act == ipid_pkg::ACT_CLEAR) begin
      clear_words++;
      for (int a = 0; a < ipid_pkg::AXES; a++) begin
        err_last[a]  = '0;
        err_older[a] = '0;
        accum[a]     = '0;
      end
    end else begin
      k0 = longint'(kp) + longint'(ki) + longint'(kd);
      k1 = -longint'(kp) - 2 * longint'(kd);
      k2 = longint'(kd);
      for (int a = 0; a < ipid_pkg::AXES; a++) begin
        meas = samples[a*TB_SAMPLE_W +: TB_SAMPLE_W];
        e    = longint'(setpoint[a]) - longint'(meas);
        sum  = longint'(accum[a]) + k0 * e + k1 * longint'(err_last[a])
               + k2 * longint'(err_older[a]);
        // exact sum clipped to the 40-bit accumulator
        if (sum > ACC_HI) begin
          sum = ACC_HI;
          w.clipped[a] = 1'b1;
        end else if (sum < ACC_LO) begin
          sum = ACC_LO;
          w.clipped[a] = 1'b1;
        end
        accum[a]     = sum[ipid_pkg::ACC_W-1:0];
        err_older[a] = err_last[a];
        err_last[a]  = e[ERR_W-1:0];
        // arithmetic shift = floor, so negative drives round down
        whole = sum >>> TB_FRAC_BITS;
        if (whole > OUT_HI) begin
          whole = OUT_HI;
          w.clipped[a] = 1'b1;
        end else if (whole < OUT_LO) begin
          whole = OUT_LO;
          w.clipped[a] = 1'b1;
        end
        w.drive[a] = whole[ipid_pkg::OUT_W-1:0];
      end
    end
    drive_q.push_back(w);
  endfunction

  task check_result(logic [3*ipid_pkg::OUT_W-1:0] data, logic [ipid_pkg::AXES-1:0] flags);
    drive_word_t w;
    if (drive_q.size() == 0) begin
      report_mismatch($sformatf("output word %h/%b with nothing expected", data, flags));
      return;
    end
    w = drive_q.pop_front();
    for (int a = 0; a < ipid_pkg::AXES; a++)
      if (data[a*ipid_pkg::OUT_W +: ipid_pkg::OUT_W] !== w.drive[a])
        report_mismatch($sformatf("word %0d axis %0d drive got %0d exp %0d",
                                  words_checked, a,
                                  $signed(data[a*ipid_pkg::OUT_W +: ipid_pkg::OUT_W]),
                                  $signed(w.drive[a])));
    if (flags !== w.clipped)
      report_mismatch($sformatf("word %0d clip flags got %b exp %b",
                                words_checked, flags, w.clipped));
    if (w.clipped != '0)
      clip_words++;
    words_checked++;
  endtask
endclass

module tb_incremental_pid_three_axis_core;

  // idle cycles allowed with no word moving anywhere before giving up
  localparam int STALL_LIMIT = 2000;
  // cycles to let pass after the last result, as a margin
  localparam int TAIL_CYCLES = 8;

  localparam logic [TB_SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
  localparam logic [TB_SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [TB_SAMPLE_W-1:0] SAMPLE_NEG1 = 16'hFFFF;
  localparam logic [ipid_pkg::CFG_DAT_W-1:0] GAIN_MAX = 16'h7FFF;
  localparam logic [ipid_pkg::CFG_DAT_W-1:0] GAIN_MIN = 16'h8000;

  // indexes the block has no register for
  localparam logic [ipid_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [ipid_pkg::CFG_IDX_W-1:0] IDX_UNMAPPED_HI = 3'd7;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic [3*TB_SAMPLE_W-1:0]            in_tdata = '0;
  logic [0:0]                          in_tuser = '0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [3*ipid_pkg::OUT_W-1:0]        out_tdata;
  logic [ipid_pkg::AXES-1:0]           out_tuser;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [ipid_pkg::CFG_DAT_W-1:0]      cfg_data = '0;

  pid_scoreboard sb;
  bit  steady;          // phase without any idling on either side
  int  ready_hold;
  int  idle_cycles;
  int  phases;

  incremental_pid_three_axis_core #(
    .SAMPLE_WIDTH   (TB_SAMPLE_W),
    .GAIN_FRAC_BITS (TB_FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // favored value at favor_pct percent, a corner now and then, else anything
  function automatic logic [TB_SAMPLE_W-1:0] pick_sample(logic [TB_SAMPLE_W-1:0] favored,
                                                         int favor_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < favor_pct)
      return favored;
    if (r < favor_pct + 10) begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return SAMPLE_NEG1;
        default: return '0;
      endcase
    end
    return TB_SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // Receiver: random stalls of random length; held high in steady phases.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // Monitor and watchdog. Everything is sampled at the edge, before the
  // block's registers and the driver's nonblocking updates take effect.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready)
        sb.note_input(ipid_pkg::action_t'(in_tuser[0]), in_tdata);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("[%0t] no word moved for %0d cycles, %0d results outstanding",
               $realtime, STALL_LIMIT, sb.pending());
      $display("incremental_pid_three_axis_core test failed");
      $finish;
    end
  end

  // One input word. valid stays high from word to word unless a gap is drawn.
  task automatic send_word(ipid_pkg::action_t act, logic [TB_SAMPLE_W-1:0] mx,
                           logic [TB_SAMPLE_W-1:0] my, logic [TB_SAMPLE_W-1:0] mz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser[0] <= act;
    in_tdata    <= {mz, my, mx};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop the input side and wait until every expected word is back; the
  // first edge lets the monitor note the last word, the extra cycles cover
  // the output register before a register write.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // cfg_valid is left high; the caller lowers it after the last write
  task automatic write_reg(logic [ipid_pkg::CFG_IDX_W-1:0] idx,
                           logic [ipid_pkg::CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(logic [ipid_pkg::CFG_DAT_W-1:0] tx,
                                logic [ipid_pkg::CFG_DAT_W-1:0] ty,
                                logic [ipid_pkg::CFG_DAT_W-1:0] tz,
                                logic [ipid_pkg::CFG_DAT_W-1:0] gp,
                                logic [ipid_pkg::CFG_DAT_W-1:0] gi,
                                logic [ipid_pkg::CFG_DAT_W-1:0] gd);
    settle();
    write_reg(ipid_pkg::REG_TARGET_X, tx);
    write_reg(ipid_pkg::REG_TARGET_Y, ty);
    write_reg(ipid_pkg::REG_TARGET_Z, tz);
    write_reg(ipid_pkg::REG_GAIN_P, gp);
    write_reg(ipid_pkg::REG_GAIN_I, gi);
    write_reg(ipid_pkg::REG_GAIN_D, gd);
    cfg_valid <= 1'b0;
    phases++;
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // A run of random words. The favored samples steer the error toward a
  // chosen sign so the accumulators can be driven into their limits.
  task automatic run_phase(int count, int clear_pct, logic [TB_SAMPLE_W-1:0] fav_x,
                           logic [TB_SAMPLE_W-1:0] fav_y, logic [TB_SAMPLE_W-1:0] fav_z,
                           int favor_pct);
    ipid_pkg::action_t act;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < clear_pct)
        act = ipid_pkg::ACT_CLEAR;
      else
        act = ipid_pkg::ACT_RUN;
      send_word(act, pick_sample(fav_x, favor_pct), pick_sample(fav_y, favor_pct),
                pick_sample(fav_z, favor_pct));
    end
  endtask

  function automatic logic [ipid_pkg::CFG_DAT_W-1:0] small_gain();
    return ipid_pkg::CFG_DAT_W'($signed($urandom_range(0, 2048)) - 1024);
  endfunction

  function automatic logic [ipid_pkg::CFG_DAT_W-1:0] any_word();
    return ipid_pkg::CFG_DAT_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    sb = new();
    steady      = 1'b0;
    ready_hold  = 0;
    idle_cycles = 0;
    phases      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset gains (p=2.0, i=3/256, d=0), zero targets ---
    send_word(ipid_pkg::ACT_RUN, '0, '0, '0);
    send_word(ipid_pkg::ACT_RUN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_NEG1);
    send_word(ipid_pkg::ACT_RUN, SAMPLE_MIN, SAMPLE_MAX, 16'd1);
    // clear ignores its samples
    send_word(ipid_pkg::ACT_CLEAR, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_word(ipid_pkg::ACT_RUN, 16'd12345, -16'sd23456, 16'd100);
    // small negative drive: floor, not truncation
    send_word(ipid_pkg::ACT_RUN, SAMPLE_NEG1, SAMPLE_NEG1, 16'd3);

    // writes to unmapped indexes must leave every register as it was
    settle();
    write_reg(IDX_UNMAPPED_LO, GAIN_MAX);
    write_reg(IDX_UNMAPPED_HI, GAIN_MIN);
    cfg_valid <= 1'b0;
    send_word(ipid_pkg::ACT_RUN, 16'd7, -16'sd7, '0);
    send_word(ipid_pkg::ACT_RUN, 16'd9, SAMPLE_NEG1, 16'd2);

    // extreme targets and gains, largest errors of both signs
    apply_settings(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_NEG1, GAIN_MAX, GAIN_MIN, GAIN_MIN);
    send_word(ipid_pkg::ACT_RUN, SAMPLE_MIN, SAMPLE_MAX, '0);
    send_word(ipid_pkg::ACT_RUN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN);
    send_word(ipid_pkg::ACT_RUN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
    send_word(ipid_pkg::ACT_CLEAR, '0, '0, '0);
    send_word(ipid_pkg::ACT_RUN, '0, '0, '0);
    send_word(ipid_pkg::ACT_RUN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);

    // --- random phases ---
    apply_settings(any_word(), any_word(), any_word(), small_gain(), small_gain(),
                   small_gain());
    run_phase(200, 3, '0, '0, '0, 0);

    apply_settings(any_word(), any_word(), any_word(), any_word(), any_word(), any_word());
    run_phase(200, 5, '0, '0, '0, 0);

    // full positive error and full gains: the integral term walks every
    // accumulator into its upper limit in a few hundred updates
    apply_settings(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    send_word(ipid_pkg::ACT_CLEAR, '0, '0, '0);
    run_phase(320, 0, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 88);

    // full negative error with positive integral gain: lower limit
    apply_settings(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, GAIN_MIN, GAIN_MAX, GAIN_MIN);
    send_word(ipid_pkg::ACT_CLEAR, '0, '0, '0);
    run_phase(320, 0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 88);

    // zero gains: drives hold whatever the accumulators had
    apply_settings(SAMPLE_MAX, SAMPLE_MIN, 16'd1000, '0, '0, '0);
    run_phase(60, 5, '0, '0, '0, 0);

    apply_settings(any_word(), any_word(), any_word(), small_gain(), small_gain(),
                   small_gain());
    run_phase(120, 20, '0, '0, '0, 0);

    // drain: the watchdog bounds this wait
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));

    $display("covered %0d register settings, %0d result words checked, %0d clear words",
             phases, sb.words_checked, sb.clear_words);
    $display("%0d words carried clip flags, %0d mismatches", sb.clip_words, sb.mismatches);
    if (sb.mismatches == 0)
      $display("incremental_pid_three_axis_core test passed");
    else
      $display("incremental_pid_three_axis_core test failed");
    $finish;
  end

endmodule
